// ===== design/mpsm_pkg.sv =====
// shared types and constants of the multi-pattern subsequence matcher
package mpsm_pkg;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int POS_W    = 3;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 3;
    localparam int PIU_W    = 4;

    localparam int ENTRY_FIELDS = 4;
    localparam int ENTRY_WIDTH  = 4;

    localparam int DEF_MAX_PATTERNS   = 8;
    localparam int DEF_MAX_COMPONENTS = 8;
    localparam int DEF_INDEX_WIDTH    = 16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index taken from paddr[APB_AW-1:2]
    localparam logic [APB_AW-3:0] REG_PATTERNS_IN_USE = '0;
    localparam logic [PIU_W-1:0]  PIU_RESET           = PIU_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_COMPONENT = 2'd0,
        FUNC_LENGTH    = 2'd1,
        FUNC_ENTRY     = 2'd2
    } t_func;

    typedef struct packed {
        logic                    valid;
        t_func                   func;
        logic [SLOT_W-1:0]       slot;
        logic [POS_W-1:0]        pos;
        logic [VALUE_W-1:0]      value;
        logic [ENTRY_FIELDS-1:0] cmask;
        logic                    last;
    } t_ctl;

endpackage

// ===== design/mpsm_if.sv =====
// item and result channel interfaces of the matcher
interface mpsm_item_if #(
    parameter int INDEX_WIDTH = mpsm_pkg::DEF_INDEX_WIDTH
);
    import mpsm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [SLOT_W-1:0]      pattern_slot;
    logic [POS_W-1:0]       component_pos;
    logic [VALUE_W-1:0]     load_value;
    logic [INDEX_WIDTH-1:0] entry_index_0;
    logic [INDEX_WIDTH-1:0] entry_index_1;
    logic [INDEX_WIDTH-1:0] entry_index_2;
    logic [INDEX_WIDTH-1:0] entry_index_3;
    logic [COUNT_W-1:0]     entry_count;
    logic                   last_entry;

    modport source (
        output valid, func, pattern_slot, component_pos, load_value,
               entry_index_0, entry_index_1, entry_index_2, entry_index_3,
               entry_count, last_entry,
        input  ready
    );
    modport sink (
        input  valid, func, pattern_slot, component_pos, load_value,
               entry_index_0, entry_index_1, entry_index_2, entry_index_3,
               entry_count, last_entry,
        output ready
    );
endinterface

interface mpsm_result_if #(
    parameter int MAX_PATTERNS = mpsm_pkg::DEF_MAX_PATTERNS
);
    logic                    valid;
    logic                    ready;
    logic [MAX_PATTERNS-1:0] found_mask;
    logic                    scan_done;

    modport source (output valid, found_mask, scan_done, input ready);
    modport sink (input valid, found_mask, scan_done, output ready);
endinterface

// ===== design/mpsm_cell.sv =====
// one pattern slot of the matching chain
module mpsm_cell #(
    parameter int MAX_PATTERNS   = mpsm_pkg::DEF_MAX_PATTERNS,
    parameter int MAX_COMPONENTS = mpsm_pkg::DEF_MAX_COMPONENTS,
    parameter int INDEX_WIDTH    = mpsm_pkg::DEF_INDEX_WIDTH,
    parameter int SLOT           = 0
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_adv,
    input  logic [mpsm_pkg::PIU_W-1:0]                         i_piu,
    input  mpsm_pkg::t_ctl                                     i_ctl,
    input  logic [mpsm_pkg::ENTRY_FIELDS-1:0][INDEX_WIDTH-1:0] i_idx,
    input  logic [MAX_PATTERNS-1:0]                            i_mask,
    output mpsm_pkg::t_ctl                                     o_ctl,
    output logic [mpsm_pkg::ENTRY_FIELDS-1:0][INDEX_WIDTH-1:0] o_idx,
    output logic [MAX_PATTERNS-1:0]                            o_mask
);
    import mpsm_pkg::*;

    localparam int PW = $clog2(MAX_COMPONENTS + 1);

    logic [INDEX_WIDTH-1:0] r_comp [MAX_COMPONENTS];
    logic [PW-1:0]          r_prog, n_prog;
    logic [PW-1:0]          r_len, n_len;
    logic                   r_found, n_found;
    t_ctl                   r_ctl;
    logic [ENTRY_FIELDS-1:0][INDEX_WIDTH-1:0] r_idx;
    logic [MAX_PATTERNS-1:0] r_mask, n_mask;

    logic [INDEX_WIDTH-1:0] want;
    logic [PW-1:0]          nxt;
    logic                   hit, sel, active, searching, wr_comp, vis;

    assign sel    = (32'(i_ctl.slot) == SLOT);
    assign active = (32'(i_piu) > SLOT);
    assign nxt    = r_prog + PW'(1);
    assign searching = active && !r_found && (32'(r_prog) < MAX_COMPONENTS);
    assign wr_comp = i_adv && i_ctl.valid && (i_ctl.func == FUNC_COMPONENT) && sel;

    always_comb begin
        want = '0;
        for (int j = 0; j < MAX_COMPONENTS; j++) begin
            if (r_prog == PW'(j)) begin
                want = r_comp[j];
            end
        end
    end

    always_comb begin
        hit = 1'b0;
        for (int n = 0; n < ENTRY_FIELDS; n++) begin
            hit = hit | (i_ctl.cmask[n] & (i_idx[n] == want));
        end
    end

    always_comb begin
        n_prog  = r_prog;
        n_len   = r_len;
        n_found = r_found;
        if (i_ctl.valid) begin
            unique case (i_ctl.func)
                FUNC_LENGTH: begin
                    if (sel) begin
                        if (i_ctl.value == '0) begin
                            n_len = PW'(1);
                        end else if (32'(i_ctl.value) > MAX_COMPONENTS) begin
                            n_len = PW'(MAX_COMPONENTS);
                        end else begin
                            n_len = PW'(i_ctl.value);
                        end
                        n_prog  = '0;
                        n_found = 1'b0;
                    end
                end
                FUNC_ENTRY: begin
                    if (searching && hit) begin
                        n_prog = nxt;
                        if (nxt >= r_len) begin
                            n_found = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        // the result shows the flag before an end-of-scan clear
        vis = n_found;
        if (i_ctl.valid && (i_ctl.func == FUNC_ENTRY) && i_ctl.last) begin
            n_prog  = '0;
            n_found = 1'b0;
        end
        n_mask       = i_mask;
        n_mask[SLOT] = vis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog  <= '0;
            r_len   <= PW'(1);
            r_found <= 1'b0;
            r_ctl   <= '0;
        end else if (i_adv) begin
            r_prog  <= n_prog;
            r_len   <= n_len;
            r_found <= n_found;
            r_ctl   <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_idx  <= i_idx;
            r_mask <= n_mask;
        end
        for (int j = 0; j < MAX_COMPONENTS; j++) begin
            if (wr_comp && (32'(i_ctl.pos) == j)) begin
                r_comp[j] <= INDEX_WIDTH'(i_ctl.value);
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_idx  = r_idx;
    assign o_mask = r_mask;

    a_found_vs_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found == (r_prog >= r_len))
        else $error("found flag disagrees with progress");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) && (32'(r_len) <= MAX_COMPONENTS))
        else $error("pattern length out of range");

    a_scan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_ctl.valid && (i_ctl.func == FUNC_ENTRY) && i_ctl.last)
        |=> ((r_prog == '0) && !r_found))
        else $error("slot state not cleared after last entry");

endmodule

// ===== design/multi_pattern_subsequence_matcher.sv =====
// top level: item chain of pattern cells, apb register and result stage
// an accepted item passes through the register of every cell; the last one is the result register
// throughput: one item per cycle; the chain advances as one and stalls only
//   while the result register holds a transaction the sink has not taken
// reset (synchronous, active low): lengths 1, progress and found flags 0,
//   patterns_in_use 1, chain empty; pattern components are not reset
module multi_pattern_subsequence_matcher #(
    parameter int MAX_PATTERNS   = mpsm_pkg::DEF_MAX_PATTERNS,
    parameter int MAX_COMPONENTS = mpsm_pkg::DEF_MAX_COMPONENTS,
    parameter int INDEX_WIDTH    = mpsm_pkg::DEF_INDEX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mpsm_item_if.sink                     i_item,
    mpsm_result_if.source                 o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpsm_pkg::APB_AW-1:0]   paddr,
    input  logic [mpsm_pkg::APB_DW-1:0]   pwdata,
    output logic [mpsm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import mpsm_pkg::*;

    // usable entry slots: the clamp on entry_count
    localparam int ECAP = (ENTRY_WIDTH < ENTRY_FIELDS) ? ENTRY_WIDTH : ENTRY_FIELDS;

    logic [PIU_W-1:0] r_piu;
    logic             cfg_wr;
    logic             w_adv;

    // stage k feeds cell k; the last stage is the result register
    t_ctl                                     w_ctl  [MAX_PATTERNS+1];
    logic [ENTRY_FIELDS-1:0][INDEX_WIDTH-1:0] w_idx  [MAX_PATTERNS+1];
    logic [MAX_PATTERNS-1:0]                  w_mask [MAX_PATTERNS+1];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[APB_AW-1:2] == REG_PATTERNS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu <= PIU_RESET;
        end else if (cfg_wr) begin
            r_piu <= pwdata[PIU_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == REG_PATTERNS_IN_USE) begin
            prdata = APB_DW'(r_piu);
        end
    end

    // ---------------- chain entry ----------------
    // whole chain moves when the result register is empty or being drained
    assign w_adv        = !o_result.valid || o_result.ready;
    assign i_item.ready = w_adv;

    always_comb begin
        w_ctl[0]       = '0;
        w_ctl[0].valid = i_item.valid;
        w_ctl[0].func  = t_func'(i_item.func);
        w_ctl[0].slot  = i_item.pattern_slot;
        w_ctl[0].pos   = i_item.component_pos;
        w_ctl[0].value = i_item.load_value;
        w_ctl[0].last  = i_item.last_entry;
        // counts above the entry width behave as the full width
        for (int n = 0; n < ENTRY_FIELDS; n++) begin
            w_ctl[0].cmask[n] = (32'(i_item.entry_count) > n) && (n < ECAP);
        end
    end

    assign w_idx[0][0] = i_item.entry_index_0;
    assign w_idx[0][1] = i_item.entry_index_1;
    assign w_idx[0][2] = i_item.entry_index_2;
    assign w_idx[0][3] = i_item.entry_index_3;
    assign w_mask[0]   = '0;

    // ---------------- cell chain ----------------
    // each cell updates its slot as the transaction passes and sets its mask bit
    for (genvar k = 0; k < MAX_PATTERNS; k++) begin : g_cell
        mpsm_cell #(
            .MAX_PATTERNS   (MAX_PATTERNS),
            .MAX_COMPONENTS (MAX_COMPONENTS),
            .INDEX_WIDTH    (INDEX_WIDTH),
            .SLOT           (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_piu   (r_piu),
            .i_ctl   (w_ctl[k]),
            .i_idx   (w_idx[k]),
            .i_mask  (w_mask[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_idx   (w_idx[k+1]),
            .o_mask  (w_mask[k+1])
        );
    end

    // ---------------- result ----------------
    assign o_result.valid      = w_ctl[MAX_PATTERNS].valid;
    assign o_result.found_mask = w_mask[MAX_PATTERNS];
    assign o_result.scan_done  = (w_ctl[MAX_PATTERNS].func == FUNC_ENTRY) &&
                                 w_ctl[MAX_PATTERNS].last;

    // register write lands
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_piu == $past(pwdata[PIU_W-1:0])))
        else $error("patterns_in_use write lost");

    // a stalled chain keeps its first stage
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_ctl[1].valid))
        else $error("chain moved while stalled");

    // an advancing chain with no input transaction carries a bubble into the first stage
    a_chain_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && o_result.valid && o_result.ready && !i_item.valid)
        |=> (w_ctl[1].valid == 1'b0))
        else $error("bubble not carried into the chain");

endmodule

// ===== verif/tb_multi_pattern_subsequence_matcher.sv =====
// self-checking testbench of the multi-pattern subsequence matcher
`timescale 1ns / 100ps

module tb_multi_pattern_subsequence_matcher;
    import mpsm_pkg::*;

    localparam int MAXP        = DEF_MAX_PATTERNS;
    localparam int MAXC        = DEF_MAX_COMPONENTS;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 300000;
    localparam int VALUE_POOL  = 10;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // one input transaction as the driver sends it
    typedef struct {
        bit [FUNC_W-1:0]            func;
        bit [SLOT_W-1:0]            slot;
        bit [POS_W-1:0]             pos;
        bit [VALUE_W-1:0]           value;
        bit [ENTRY_FIELDS-1:0][15:0] idx;
        bit [COUNT_W-1:0]           count;
        bit                         last;
    } t_item;

    typedef struct {
        bit [MAXP-1:0] found_mask;
        bit            scan_done;
    } t_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    mpsm_item_if   item_ch ();
    mpsm_result_if result_ch ();

    multi_pattern_subsequence_matcher uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // matcher state as predicted from accepted transactions
    bit [15:0]     model_store [MAXP*MAXC];
    bit [3:0]      model_len   [MAXP];
    bit [3:0]      model_prog  [MAXP];
    bit [MAXP-1:0] model_found;
    bit [3:0]      model_piu;

    // stimulus side view of which components hold a known value
    bit [15:0] gen_comp    [MAXP*MAXC];
    bit        gen_written [MAXP*MAXC];
    bit [15:0] value_pool  [VALUE_POOL];

    t_item   pending_items [$];
    t_result expected_results [$];

    int  src_idle_pct;
    int  snk_stall_pct;
    bit  long_hold;
    int  hold_count;
    bit  in_taken;
    int  mismatch_count;
    int  cycle_count;

    // clock, 20 ns period
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // found mask after one transaction, and the state update it causes
    function automatic t_result predict_result(input t_item it);
        t_result r;
        int      used;
        int      cnt;
        bit      hit;
        bit [15:0] want;
        r.scan_done = 1'b0;
        case (it.func)
            FUNC_COMPONENT: model_store[it.slot*MAXC + it.pos] = it.value;
            FUNC_LENGTH: begin
                if (it.value == 0)
                    model_len[it.slot] = 4'd1;
                else if (it.value > MAXC)
                    model_len[it.slot] = 4'(MAXC);
                else
                    model_len[it.slot] = 4'(it.value);
                model_prog[it.slot]  = '0;
                model_found[it.slot] = 1'b0;
            end
            FUNC_ENTRY: begin
                cnt  = (it.count > ENTRY_WIDTH) ? ENTRY_WIDTH : it.count;
                used = (model_piu > MAXP) ? MAXP : model_piu;
                for (int k = 0; k < used; k++) begin
                    if (!model_found[k] && model_prog[k] < MAXC) begin
                        want = model_store[k*MAXC + model_prog[k]];
                        hit  = 1'b0;
                        for (int n = 0; n < cnt; n++)
                            hit |= (it.idx[n] == want);
                        if (hit) begin
                            model_prog[k] = model_prog[k] + 1'b1;
                            if (model_prog[k] >= model_len[k])
                                model_found[k] = 1'b1;
                        end
                    end
                end
                r.scan_done = it.last;
            end
            default: ;
        endcase
        r.found_mask = model_found;
        // end of scan clears all progress after the result is formed
        if (r.scan_done) begin
            for (int k = 0; k < MAXP; k++)
                model_prog[k] = '0;
            model_found = '0;
        end
        return r;
    endfunction

    // number of leading components of a slot that hold a known value
    function automatic int written_prefix(input int s);
        int n;
        n = 0;
        while (n < MAXC && gen_written[s*MAXC + n])
            n++;
        return n;
    endfunction

    function automatic bit [15:0] pick_value();
        if ($urandom_range(9) < 8)
            return value_pool[$urandom_range(VALUE_POOL-1)];
        return 16'($urandom_range(65535));
    endfunction

    // entry index: mostly a stored component so that patterns advance
    function automatic bit [15:0] pick_index();
        int s;
        if ($urandom_range(99) < 65) begin
            s = $urandom_range(MAXP-1);
            return gen_comp[s*MAXC + $urandom_range(written_prefix(s)-1)];
        end
        return pick_value();
    endfunction

    function automatic t_item load_item(input bit [FUNC_W-1:0] f, input int s, input int p,
                                        input bit [15:0] v);
        t_item it;
        it.func  = f;
        it.slot  = 3'(s);
        it.pos   = 3'(p);
        it.value = v;
        for (int n = 0; n < ENTRY_FIELDS; n++)
            it.idx[n] = 16'($urandom);
        it.count = 3'($urandom_range(7));
        it.last  = 1'($urandom_range(1));
        if (f == FUNC_COMPONENT) begin
            gen_comp[s*MAXC + p]    = v;
            gen_written[s*MAXC + p] = 1'b1;
        end
        return it;
    endfunction

    function automatic t_item entry_item(input bit [15:0] i0, input bit [15:0] i1,
                                         input bit [15:0] i2, input bit [15:0] i3,
                                         input int cnt, input bit lst);
        t_item it;
        it.func  = FUNC_ENTRY;
        it.slot  = 3'($urandom_range(7));
        it.pos   = 3'($urandom_range(7));
        it.value = 16'($urandom);
        it.idx   = {i3, i2, i1, i0};
        it.count = 3'(cnt);
        it.last  = lst;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    sel;
        int    s;
        int    p;
        int    len;
        bit [15:0] v;
        sel = $urandom_range(99);
        s   = $urandom_range(MAXP-1);
        if (sel < 14) begin
            // mostly grow a pattern at its first unwritten position
            p = written_prefix(s);
            if (p >= MAXC || $urandom_range(3) == 0)
                p = $urandom_range(MAXC-1);
            it = load_item(FUNC_COMPONENT, s, p, pick_value());
        end else if (sel < 21) begin
            // length never reaches past the written components
            len = $urandom_range(written_prefix(s), 1);
            v   = 16'(len);
            if (len == 1 && $urandom_range(1))
                v = '0;
            if (len == MAXC && $urandom_range(1))
                v = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(65535, MAXC+1));
            it = load_item(FUNC_LENGTH, s, $urandom_range(7), v);
        end else if (sel < 24) begin
            it = load_item(FUNC_UNUSED, s, $urandom_range(7), 16'($urandom));
        end else begin
            sel = $urandom_range(19);
            it = entry_item(pick_index(), pick_index(), pick_index(), pick_index(),
                            (sel == 0) ? 0 : (sel < 3) ? $urandom_range(7, 5)
                                                       : $urandom_range(4, 1),
                            $urandom_range(9) == 0);
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 10)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // append one transaction to the driver queue
    task automatic add_pending(input t_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // input side: hold each transaction until it is taken
    always @(negedge i_clk) begin : driver
        t_item nxt;
        if (!item_ch.valid || in_taken) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = pending_items.pop_front();
                item_ch.func          <= nxt.func;
                item_ch.pattern_slot  <= nxt.slot;
                item_ch.component_pos <= nxt.pos;
                item_ch.load_value    <= nxt.value;
                item_ch.entry_index_0 <= nxt.idx[0];
                item_ch.entry_index_1 <= nxt.idx[1];
                item_ch.entry_index_2 <= nxt.idx[2];
                item_ch.entry_index_3 <= nxt.idx[3];
                item_ch.entry_count   <= nxt.count;
                item_ch.last_entry    <= nxt.last;
                item_ch.valid         <= 1'b1;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // long back-pressure window, counted on its own
    always @(negedge i_clk) begin
        if (long_hold && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    always @(negedge i_clk) begin
        result_ch.ready <= !(long_hold && hold_count < HOLD_CYCLES)
                           && ($urandom_range(99) >= snk_stall_pct);
    end

    // accepted inputs feed the predictor, accepted results are checked
    always @(posedge i_clk) begin : monitor
        t_item   got;
        t_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready) begin
                got.func  = item_ch.func;
                got.slot  = item_ch.pattern_slot;
                got.pos   = item_ch.component_pos;
                got.value = item_ch.load_value;
                got.idx   = {item_ch.entry_index_3, item_ch.entry_index_2,
                             item_ch.entry_index_1, item_ch.entry_index_0};
                got.count = item_ch.entry_count;
                got.last  = item_ch.last_entry;
                expected_results.insert(expected_results.size(), predict_result(got));
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction: mask %02h done %0d",
                                              result_ch.found_mask, result_ch.scan_done));
                end else begin
                    want = expected_results.pop_front();
                    if (result_ch.found_mask !== want.found_mask)
                        report_mismatch($sformatf("found_mask expected %02h got %02h",
                                                  want.found_mask, result_ch.found_mask));
                    if (result_ch.scan_done !== want.scan_done)
                        report_mismatch($sformatf("scan_done expected %0d got %0d",
                                                  want.scan_done, result_ch.scan_done));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // wait until every transaction is sent and every result is back
    // checked at the rising edge, where the driver outputs and queue are settled
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
    endtask

    task automatic write_patterns_in_use(input bit [3:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_PATTERNS_IN_USE, 2'b00};
        pwdata  = {28'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        model_piu = value;
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input bit [3:0] piu,
                             input int n_items, input bit pressure);
        wait_drained();
        write_patterns_in_use(piu);
        @(posedge i_clk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        long_hold     = pressure;
        repeat (n_items)
            add_pending(random_item());
    endtask

    initial begin
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        item_ch.valid         = 1'b0;
        item_ch.func          = '0;
        item_ch.pattern_slot  = '0;
        item_ch.component_pos = '0;
        item_ch.load_value    = '0;
        item_ch.entry_index_0 = '0;
        item_ch.entry_index_1 = '0;
        item_ch.entry_index_2 = '0;
        item_ch.entry_index_3 = '0;
        item_ch.entry_count   = '0;
        item_ch.last_entry    = 1'b0;
        result_ch.ready       = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        long_hold      = 1'b0;
        hold_count     = 0;
        in_taken       = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;

        // predictor reset
        for (int k = 0; k < MAXP; k++) begin
            model_len[k]  = 4'd1;
            model_prog[k] = '0;
        end
        model_found = '0;
        model_piu   = PIU_RESET;

        value_pool[0] = 16'h0000;
        value_pool[1] = 16'hFFFF;
        for (int n = 2; n < VALUE_POOL; n++)
            value_pool[n] = 16'($urandom_range(65535));

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, one pattern in use after reset
        // first component of every slot, extremes in slots 0 and 1
        add_pending(load_item(FUNC_COMPONENT, 0, 0, 16'h0000));
        add_pending(load_item(FUNC_COMPONENT, 1, 0, 16'hFFFF));
        for (int s = 2; s < MAXP; s++)
            add_pending(load_item(FUNC_COMPONENT, s, 0, pick_value()));
        add_pending(load_item(FUNC_COMPONENT, 0, 1, 16'h1234));
        add_pending(load_item(FUNC_COMPONENT, 7, 7, 16'hFFFF));
        add_pending(load_item(FUNC_LENGTH, 0, 0, 16'd2));
        // zero length is stored as one
        add_pending(load_item(FUNC_LENGTH, 1, 0, 16'd0));
        // empty entry matches nothing
        add_pending(entry_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 1'b0));
        add_pending(entry_item(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b0));
        add_pending(load_item(FUNC_UNUSED, 5, 3, 16'hA5A5));
        // oversized count still reaches the fourth index and completes slot 0
        add_pending(entry_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1234, 7, 1'b0));
        add_pending(entry_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4, 1'b1));
        add_pending(entry_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 1'b1));
        // length write mid-scan restarts the pattern
        add_pending(entry_item(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 2, 1'b0));
        add_pending(load_item(FUNC_LENGTH, 0, 0, 16'd2));
        add_pending(entry_item(16'h1234, 16'h1234, 16'h1234, 16'h1234, 4, 1'b0));
        add_pending(entry_item(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b0));
        add_pending(entry_item(16'hFFFF, 16'h1234, 16'hFFFF, 16'hFFFF, 3, 1'b0));
        add_pending(entry_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4, 1'b1));

        // random phases: idling mix, register setting, transaction count, long hold
        run_phase(0,  0,  4'd8,  250, 1'b0);
        run_phase(83, 0,  4'd3,  150, 1'b0);
        run_phase(0,  83, 4'd15, 250, 1'b0);
        run_phase(25, 25, 4'd0,  60,  1'b0);
        run_phase(25, 25, 4'd9,  250, 1'b0);
        run_phase(0,  0,  4'd5,  150, 1'b1);
        run_phase(25, 25, 4'd1,  150, 1'b0);
        run_phase(0,  0,  4'd8,  200, 1'b0);

        wait_drained();
        repeat (MAXP + 4) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
